// ===== rtl/bfpa_pkg.sv =====
// Package for the best-fit partition allocator.
// Holds the transfer payload types, command codes and parameter defaults.
// No dependencies.
package bfpa_pkg;

  localparam int unsigned PartitionsDef = 16;
  localparam int unsigned SizeBitsDef   = 16;

  localparam int unsigned IndexW  = 4;
  localparam int unsigned AmountW = 16;
  localparam int unsigned CfgW    = 5;
  localparam int unsigned PaddrW  = 3;

  // register byte address bit 2 selects the register index
  localparam logic RegPartitionsInUse = 1'b0;
  localparam logic [CfgW-1:0] PartitionsInUseRst = 5'd16;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdAlloc = 1'b1;

  typedef struct packed {
    logic               command;
    logic [IndexW-1:0]  partition_index;
    logic [AmountW-1:0] amount;
  } in_t;

  typedef struct packed {
    logic               granted;
    logic [IndexW-1:0]  chosen_partition;
    logic [AmountW-1:0] remaining_after;
  } out_t;

endpackage

// ===== rtl/best_fit_partition_allocator.sv =====
// Best-fit partition allocator, top level.
// Free-size table, scan sequencer with one shared compare unit, APB register.
// Depends on bfpa_pkg.
//
// Usage: items arrive on in_valid_i/in_ready_o as bfpa_pkg::in_t. A load
// writes one partition's free size; an allocate scans partitions 0 to
// min(partitions_in_use, PARTITIONS)-1 one per cycle through a single
// compare unit, picks the smallest size that fits (lowest index on a tie),
// subtracts the request and reports it. Every item gives one result on
// out_valid_o/out_ready_i as bfpa_pkg::out_t.
// A load passes through the done state into the output register; an allocate
// passes through scan, write and done, its scan paced by the one-read-per-cycle
// table port. A new item is taken only after the last has left the done state,
// and in_ready_o is high only while the sequencer is idle.
// A finished result waits in the output register; the next item is taken
// meanwhile, and its own result waits until the register drains.
// Reset clears every table entry to zero through per-entry valid bits and
// sets partitions_in_use to 16. Write the register only while idle.
module best_fit_partition_allocator #(
  parameter int unsigned PARTITIONS = bfpa_pkg::PartitionsDef,
  parameter int unsigned SIZE_BITS  = bfpa_pkg::SizeBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bfpa_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bfpa_pkg::out_t              out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfpa_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned IdxW = $clog2(PARTITIONS);
  localparam int unsigned CntW = $clog2(PARTITIONS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_e;

  state_e                       state_q;
  logic [bfpa_pkg::CfgW-1:0]    cfg_q;
  logic [CntW-1:0]              lim_q, ptr_q, lim_d;
  logic [SIZE_BITS-1:0]         amt_q, best_size_q, rd_data_q, cur_size, diff;
  logic [IdxW-1:0]              best_q, rd_idx_q;
  logic                         found_q, rd_vld_q, rd_ent_vld_q, fits;
  logic [PARTITIONS-1:0]        valid_q;
  logic [SIZE_BITS-1:0]         mem_q [PARTITIONS];
  logic                         mem_we, in_xfer, load_hit;
  logic [IdxW-1:0]              mem_waddr;
  logic [SIZE_BITS-1:0]         mem_wdata;
  bfpa_pkg::out_t               res_q, out_q;
  logic                         out_valid_q;

  // APB register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bfpa_pkg::PartitionsInUseRst;
    end else if (psel && penable && pwrite && paddr[2] == bfpa_pkg::RegPartitionsInUse) begin
      cfg_q <= pwdata[bfpa_pkg::CfgW-1:0];
    end
  end
  assign prdata = (paddr[2] == bfpa_pkg::RegPartitionsInUse) ?
                  {{(32 - bfpa_pkg::CfgW){1'b0}}, cfg_q} : 32'd0;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign load_hit   = (int'(in_data_i.partition_index) < int'(PARTITIONS));

  always_comb begin
    if (int'(cfg_q) > int'(PARTITIONS)) begin
      lim_d = CntW'(PARTITIONS);
    end else begin
      lim_d = CntW'(cfg_q);
    end
  end

  // shared compare / subtract unit
  assign cur_size = rd_ent_vld_q ? rd_data_q : '0;
  assign fits     = rd_vld_q && (cur_size >= amt_q) && (!found_q || cur_size < best_size_q);
  assign diff     = best_size_q - amt_q;

  // single write port of the table
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_q;
    mem_wdata = diff;
    if (in_xfer && in_data_i.command == bfpa_pkg::CmdLoad && load_hit) begin
      mem_we    = 1'b1;
      mem_waddr = IdxW'(in_data_i.partition_index);
      mem_wdata = SIZE_BITS'(in_data_i.amount);
    end else if (state_q == ST_WRITE && found_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[ptr_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[mem_waddr] <= 1'b1;
    end
  end

  // payload registers of the sequencer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      amt_q <= SIZE_BITS'(in_data_i.amount);
      lim_q <= lim_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ptr_q        <= '0;
      rd_vld_q     <= 1'b0;
      rd_ent_vld_q <= 1'b0;
      rd_idx_q     <= '0;
      found_q      <= 1'b0;
      best_q       <= '0;
      best_size_q  <= '0;
      res_q        <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          ptr_q    <= '0;
          rd_vld_q <= 1'b0;
          found_q  <= 1'b0;
          if (in_xfer) begin
            if (in_data_i.command == bfpa_pkg::CmdLoad) begin
              res_q.granted          <= 1'b0;
              res_q.chosen_partition <= in_data_i.partition_index;
              res_q.remaining_after  <= load_hit ?
                  bfpa_pkg::AmountW'(SIZE_BITS'(in_data_i.amount)) : '0;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_vld_q     <= (ptr_q != lim_q);
          rd_idx_q     <= ptr_q[IdxW-1:0];
          rd_ent_vld_q <= valid_q[ptr_q[IdxW-1:0]];
          if (ptr_q != lim_q) begin
            ptr_q <= ptr_q + 1'b1;
          end
          if (fits) begin
            found_q     <= 1'b1;
            best_q      <= rd_idx_q;
            best_size_q <= cur_size;
          end
          if (ptr_q == lim_q && !rd_vld_q) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (found_q) begin
            res_q.granted          <= 1'b1;
            res_q.chosen_partition <= bfpa_pkg::IndexW'(best_q);
            res_q.remaining_after  <= bfpa_pkg::AmountW'(diff);
          end else begin
            res_q <= '0;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/bfpa_checker.sv =====
// Port-level checker for the best-fit partition allocator, with its bind.
// Depends on bfpa_pkg and best_fit_partition_allocator.
module bfpa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input bfpa_pkg::out_t out_data_o,
  input logic           pready
);

  // pending result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // one item at a time
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // a new result is only produced while busy
  a_result_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared from idle");

  // handshake outputs always known
  a_known_handshake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready_o, out_valid_o}))
    else $error("handshake output unknown");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind best_fit_partition_allocator bfpa_checker u_bfpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);
